FILE: hdl/force_gauge_baseline_peak_hold_macros.svh
// assertion macros shared by the force gauge checker
`ifndef FORCE_GAUGE_BASELINE_PEAK_HOLD_MACROS_SVH
`define FORCE_GAUGE_BASELINE_PEAK_HOLD_MACROS_SVH

// same-cycle implication, held off while reset is asserted
`define FGBPH_ASSERT_NOW(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("force gauge check failed");

// next-cycle implication, held off while reset is asserted
`define FGBPH_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("force gauge check failed");

`endif

FILE: hdl/fgbph_pkg.sv
// shared constants and codes for the force gauge baseline and peak hold block
package fgbph_pkg;

	// sample counter width default
	localparam int SAMPLE_COUNT_BITS_DEF = 16;

	// datapath widths
	localparam int CODE_W    = 16;
	localparam int FORCE_W   = 17;
	localparam int NUM_W     = 40;
	localparam int BSUM_W    = 32;
	localparam int BCOUNT_W  = 16;
	localparam int CNT_W     = $clog2(NUM_W + 1);

	// stream widths
	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 56;
	localparam int M_PAD_W   = M_TDATA_W - (2 * FORCE_W + CODE_W);

	// configuration port
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_FORCE  = 2'd2;

	localparam logic [CODE_W-1:0] FULL_SCALE_RST = 16'd65535;
	localparam logic [CODE_W-1:0] TOLERANCE_RST  = 16'd308;
	localparam logic [CODE_W-1:0] MAX_FORCE_RST  = 16'd5323;

	// input kinds and report kinds
	localparam logic KIND_SAMPLE     = 1'b0;
	localparam logic KIND_EVENT      = 1'b1;
	localparam logic REPORT_FORCE    = 1'b0;
	localparam logic REPORT_BASELINE = 1'b1;

	// saturation bounds of a force value
	localparam logic signed [FORCE_W-1:0] FORCE_MAX = 17'sh0FFFF;
	localparam logic signed [FORCE_W-1:0] FORCE_MIN = 17'sh10000;
	localparam logic [NUM_W-1:0] FORCE_POS_LIM = NUM_W'(65535);
	localparam logic [NUM_W-1:0] FORCE_NEG_LIM = NUM_W'(65536);

	// saturation bounds of the block sum
	localparam logic signed [NUM_W-1:0] SUM_MAX = {1'b0, {(NUM_W-1){1'b1}}};
	localparam logic signed [NUM_W-1:0] SUM_MIN = {1'b1, {(NUM_W-1){1'b0}}};

endpackage

FILE: hdl/force_gauge_baseline_peak_hold.sv
// force gauge: baseline calibration, two-branch force map, block mean and peak hold
// a calibration sample that does not end a block goes straight into the block sum;
//   a sample after calibration first takes a pass of the serial divider for its force
// a sample that ends a block adds a divider pass for the block mean
// an end-of-calibration event takes one divider pass for the baseline
// throughput: one item at a time; s_tready is high only while the sequencer is idle
// reset: asynchronous, active low; calibration restarts, sums, counts and peak clear
module force_gauge_baseline_peak_hold #(
	parameter int SAMPLE_COUNT_BITS = fgbph_pkg::SAMPLE_COUNT_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration write port
	input  logic                                 cfg_we,
	input  logic [fgbph_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fgbph_pkg::CODE_W-1:0]         cfg_data,
	// request input
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [fgbph_pkg::S_TDATA_W-1:0]      s_tdata,   // sample[15:0]
	input  logic                                 s_tuser,   // kind[0]
	input  logic                                 s_tlast,   // last_in_block
	// report output
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [fgbph_pkg::M_TDATA_W-1:0]      m_tdata,   // mean_force[16:0],
	                                                        // peak_force[33:17],
	                                                        // baseline_code[49:34], zero pad
	output logic                                 m_tuser    // report_kind[0]
);

	// divisor width: wide enough for a sample count and for a 16-bit code span
	localparam int DEN_W  = (SAMPLE_COUNT_BITS > fgbph_pkg::CODE_W)
		? SAMPLE_COUNT_BITS : fgbph_pkg::CODE_W;
	localparam int DEN_W1 = DEN_W + 1;
	localparam int NW     = fgbph_pkg::NUM_W;
	localparam int NW1    = NW + 1;
	localparam int FW     = fgbph_pkg::FORCE_W;
	localparam int CW     = fgbph_pkg::CODE_W;
	localparam int BSW    = fgbph_pkg::BSUM_W;
	localparam int BCW    = fgbph_pkg::BCOUNT_W;

	typedef enum logic [2:0] {
		S_IDLE,   // waiting for a request
		S_MUL,    // force map: branch select and product
		S_FDIV,   // divider works out the force of one sample
		S_ADD,    // accumulate into the block sum
		S_END,    // end-of-block check
		S_MDIV,   // divider works out the block mean
		S_BDIV,   // divider works out the baseline
		S_EMIT    // hand the report to the output register
	} state_t;

	// configuration registers
	logic [CW-1:0] full_scale_q;
	logic [CW-1:0] tolerance_q;
	logic [CW-1:0] max_force_q;

	// sequencer and datapath state
	state_t                      state_q;
	logic                        calibrating_q;
	logic [BSW-1:0]              baseline_sum_q;
	logic [BCW-1:0]              block_count_q;
	logic [CW-1:0]               baseline_q;
	logic signed [NW-1:0]        block_sum_q;
	logic [SAMPLE_COUNT_BITS-1:0] sample_count_q;
	logic signed [FW-1:0]        peak_q;

	// per-request working registers
	logic [CW-1:0]               sample_q;
	logic                        last_q;
	logic signed [FW-1:0]        add_q;
	logic signed [NW-1:0]        num_q;
	logic signed [DEN_W:0]       den_q;
	logic                        start_q;
	logic                        res_kind_q;
	logic signed [FW-1:0]        res_mean_q;

	// output register
	logic                        m_tvalid_q;
	logic                        m_tuser_q;
	logic [fgbph_pkg::M_TDATA_W-1:0] m_tdata_q;

	// shared divider
	logic                        div_done;
	logic signed [FW-1:0]        div_quot;

	// force map
	logic signed [CW+1:0]        v_ext;
	logic signed [CW+1:0]        thresh;
	logic                        upper;
	logic signed [CW:0]          diff;
	logic signed [CW:0]          fden;
	logic signed [2*CW+1:0]      prod;

	// accumulators
	logic signed [NW:0]          bsum_next;
	logic signed [NW-1:0]        bsum_sat;
	logic [BSW:0]                base_next;
	logic [BSW-1:0]              base_sat;

	logic                        accept;
	logic                        count_full;
	logic                        out_free;
	logic                        start_now;
	logic                        emit;

	assign accept     = s_tvalid && s_tready;
	assign count_full = &sample_count_q;
	assign out_free   = !m_tvalid_q || m_tready;
	assign emit       = (state_q == S_EMIT) && out_free;

	// divider launch: baseline on an event, sample force, block mean at a block end
	assign start_now  = ((state_q == S_IDLE) && accept && (s_tuser == fgbph_pkg::KIND_EVENT)
		&& calibrating_q) || (state_q == S_MUL) || ((state_q == S_END) && last_q);

	// upper branch when v > b - tolerance, compared as signed values
	assign v_ext  = $signed({2'b00, sample_q});
	assign thresh = $signed({2'b00, baseline_q}) - $signed({2'b00, tolerance_q});
	assign upper  = v_ext > thresh;
	assign diff   = upper ? $signed({1'b0, sample_q}) - $signed({1'b0, baseline_q})
		: $signed({1'b0, baseline_q}) - $signed({1'b0, sample_q});
	assign fden   = upper ? $signed({1'b0, full_scale_q}) - $signed({1'b0, baseline_q})
		: $signed({1'b0, baseline_q});
	assign prod   = $signed({1'b0, max_force_q}) * diff;

	// block sum with 40-bit signed saturation
	assign bsum_next = NW1'(block_sum_q) + NW1'(add_q);
	assign bsum_sat  = (bsum_next[NW] != bsum_next[NW-1])
		? (bsum_next[NW] ? fgbph_pkg::SUM_MIN : fgbph_pkg::SUM_MAX)
		: bsum_next[NW-1:0];

	// baseline sum of block means, saturating at 32 bits
	assign base_next = {1'b0, baseline_sum_q} + (BSW+1)'(div_quot[CW-1:0]);
	assign base_sat  = base_next[BSW] ? {BSW{1'b1}} : base_next[BSW-1:0];

	fgbph_div #(
		.DEN_W (DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.num    (num_q),
		.den    (den_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	// configuration writes; an index past the list is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_scale_q <= fgbph_pkg::FULL_SCALE_RST;
			tolerance_q  <= fgbph_pkg::TOLERANCE_RST;
			max_force_q  <= fgbph_pkg::MAX_FORCE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fgbph_pkg::CFG_FULL_SCALE: full_scale_q <= cfg_data;
				fgbph_pkg::CFG_TOLERANCE:  tolerance_q  <= cfg_data;
				fgbph_pkg::CFG_MAX_FORCE:  max_force_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			calibrating_q  <= 1'b1;
			baseline_sum_q <= '0;
			block_count_q  <= '0;
			baseline_q     <= '0;
			block_sum_q    <= '0;
			sample_count_q <= '0;
			peak_q         <= '0;
			sample_q       <= '0;
			last_q         <= 1'b0;
			add_q          <= '0;
			num_q          <= '0;
			den_q          <= '0;
			start_q        <= 1'b0;
			res_kind_q     <= fgbph_pkg::REPORT_FORCE;
			res_mean_q     <= '0;
			m_tvalid_q     <= 1'b0;
			m_tuser_q      <= fgbph_pkg::REPORT_FORCE;
			m_tdata_q      <= '0;
		end else begin
			start_q <= start_now;
			if (emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						sample_q <= s_tdata[CW-1:0];
						last_q   <= s_tlast;
						if (s_tuser == fgbph_pkg::KIND_EVENT) begin
							// event outside calibration is dropped
							if (calibrating_q) begin
								num_q   <= NW'({1'b0, baseline_sum_q});
								den_q   <= DEN_W1'({1'b0, block_count_q});
								state_q <= S_BDIV;
							end
						end else if (count_full) begin
							// counter full: sample not added, block end still seen
							state_q <= S_END;
						end else if (calibrating_q) begin
							add_q   <= $signed({1'b0, s_tdata[CW-1:0]});
							state_q <= S_ADD;
						end else begin
							state_q <= S_MUL;
						end
					end
				end

				S_MUL: begin
					num_q   <= NW'(prod);
					den_q   <= DEN_W1'(fden);
					state_q <= S_FDIV;
				end

				S_FDIV: begin
					if (div_done) begin
						add_q   <= div_quot;
						state_q <= S_ADD;
					end
				end

				S_ADD: begin
					block_sum_q    <= bsum_sat;
					sample_count_q <= sample_count_q + 1'b1;
					state_q        <= S_END;
				end

				S_END: begin
					if (last_q) begin
						num_q   <= block_sum_q;
						den_q   <= DEN_W1'({1'b0, sample_count_q});
						state_q <= S_MDIV;
					end else begin
						state_q <= S_IDLE;
					end
				end

				S_MDIV: begin
					if (div_done) begin
						block_sum_q    <= '0;
						sample_count_q <= '0;
						if (calibrating_q) begin
							// block mean joins the baseline sum unless the count is full
							if (!(&block_count_q)) begin
								baseline_sum_q <= base_sat;
								block_count_q  <= block_count_q + 1'b1;
							end
							state_q <= S_IDLE;
						end else begin
							if (peak_q < div_quot) begin
								peak_q <= div_quot;
							end
							res_kind_q <= fgbph_pkg::REPORT_FORCE;
							res_mean_q <= div_quot;
							state_q    <= S_EMIT;
						end
					end
				end

				S_BDIV: begin
					if (div_done) begin
						// zero blocks gives a saturated quotient, i.e. full code
						baseline_q     <= div_quot[CW-1:0];
						calibrating_q  <= 1'b0;
						block_sum_q    <= '0;
						sample_count_q <= '0;
						res_kind_q     <= fgbph_pkg::REPORT_BASELINE;
						res_mean_q     <= '0;
						state_q        <= S_EMIT;
					end
				end

				S_EMIT: begin
					// wait for a free output register
					if (out_free) begin
						m_tuser_q  <= res_kind_q;
						m_tdata_q  <= {{fgbph_pkg::M_PAD_W{1'b0}}, baseline_q, peak_q,
							res_mean_q};
						state_q    <= S_IDLE;
					end
				end
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tdata  = m_tdata_q;

endmodule

FILE: hdl/fgbph_div.sv
// bit-serial signed divider with truncation toward zero and force-range saturation
module fgbph_div #(
	parameter int DEN_W = 16
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     start,
	input  logic signed [fgbph_pkg::NUM_W-1:0]       num,
	input  logic signed [DEN_W:0]                    den,
	output logic                                     done,
	output logic signed [fgbph_pkg::FORCE_W-1:0]     quot
);

	localparam int NW = fgbph_pkg::NUM_W;

	logic                          busy_q;
	logic                          fin_q;
	logic                          done_q;
	logic [fgbph_pkg::CNT_W-1:0]   cnt_q;
	logic [NW-1:0]                 nmag_q;
	logic [DEN_W-1:0]              dmag_q;
	logic [DEN_W-1:0]              rem_q;
	logic                          neg_q;
	logic                          numneg_q;
	logic                          zero_q;
	logic signed [fgbph_pkg::FORCE_W-1:0] quot_q;

	logic [NW-1:0]                 num_mag;
	logic [DEN_W:0]                den_abs;
	logic [DEN_W:0]                trial;
	logic [DEN_W:0]                trial_diff;
	logic                          fits;
	logic signed [fgbph_pkg::FORCE_W-1:0] fin_quot;

	assign num_mag    = num[NW-1] ? NW'(-num) : NW'(num);
	assign den_abs    = den[DEN_W] ? (DEN_W+1)'(-den) : (DEN_W+1)'(den);
	assign trial      = {rem_q, nmag_q[NW-1]};
	assign fits       = trial >= {1'b0, dmag_q};
	assign trial_diff = trial - {1'b0, dmag_q};

	// magnitude quotient to signed, saturated force
	always_comb begin
		if (zero_q) begin
			fin_quot = numneg_q ? fgbph_pkg::FORCE_MIN : fgbph_pkg::FORCE_MAX;
		end else if (neg_q) begin
			fin_quot = (nmag_q > fgbph_pkg::FORCE_NEG_LIM) ? fgbph_pkg::FORCE_MIN
				: -$signed(nmag_q[fgbph_pkg::FORCE_W-1:0]);
		end else begin
			fin_quot = (nmag_q > fgbph_pkg::FORCE_POS_LIM) ? fgbph_pkg::FORCE_MAX
				: $signed(nmag_q[fgbph_pkg::FORCE_W-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q && !start && !busy_q;
			if (start) begin
				busy_q <= 1'b1;
				fin_q  <= 1'b0;
				cnt_q  <= fgbph_pkg::CNT_W'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == fgbph_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nmag_q   <= num_mag;
			dmag_q   <= den_abs[DEN_W-1:0];
			rem_q    <= '0;
			numneg_q <= num[NW-1];
			neg_q    <= num[NW-1] ^ den[DEN_W];
			zero_q   <= (den == '0);
		end else if (busy_q) begin
			rem_q  <= fits ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
			nmag_q <= {nmag_q[NW-2:0], fits};
		end
		if (fin_q) begin
			quot_q <= fin_quot;
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

FILE: hdl/fgbph_checker.sv
// port-level checker for the force gauge block, bound to the top level
`include "force_gauge_baseline_peak_hold_macros.svh"

module fgbph_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              s_tuser,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [fgbph_pkg::M_TDATA_W-1:0]   m_tdata,
	input logic                              m_tuser
);

	// a stalled report stays offered and unchanged
	`FGBPH_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`FGBPH_ASSERT_NEXT(a_out_stable, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata))

	// an accepted sample always keeps the sequencer busy for the next cycle
	`FGBPH_ASSERT_NEXT(a_sample_busy, clk, arst_n,
		s_tvalid && s_tready && (s_tuser == fgbph_pkg::KIND_SAMPLE), !s_tready)

	// a baseline report carries a zero mean force
	`FGBPH_ASSERT_NOW(a_base_mean_zero, clk, arst_n,
		m_tvalid && (m_tuser == fgbph_pkg::REPORT_BASELINE), m_tdata[16:0] == 17'd0)

endmodule

bind force_gauge_baseline_peak_hold fgbph_checker u_fgbph_checker (.*);

FILE: sim/tb_force_gauge_baseline_peak_hold.sv
// self-checking testbench for the force gauge baseline and peak hold block
`timescale 1ns / 100ps

typedef struct packed {
	logic                                        kind;
	logic signed [fgbph_pkg::FORCE_W-1:0]        mean;
	logic signed [fgbph_pkg::FORCE_W-1:0]        peak;
	logic [fgbph_pkg::CODE_W-1:0]                baseline;
} force_report_t;

// tracks the gauge state and the reports it owes
class force_gauge_tracker;
	localparam longint COUNT_FULL = (longint'(1) << fgbph_pkg::SAMPLE_COUNT_BITS_DEF) - 1;
	localparam longint CODE_TOP   = 65535;
	localparam longint BASE_TOP   = 64'h0000_0000_FFFF_FFFF;

	longint        full_scale, tolerance, force_span;
	bit            calibrating;
	longint        base_sum, block_total, baseline, block_acc, sample_n, peak_hold;
	force_report_t reports_due[$];
	int            mismatches;

	function new();
		full_scale  = fgbph_pkg::FULL_SCALE_RST;
		tolerance   = fgbph_pkg::TOLERANCE_RST;
		force_span  = fgbph_pkg::MAX_FORCE_RST;
		calibrating = 1'b1;
		base_sum    = 0;
		block_total = 0;
		baseline    = 0;
		block_acc   = 0;
		sample_n    = 0;
		peak_hold   = 0;
		mismatches  = 0;
	endfunction

	function void set_reg(logic [fgbph_pkg::CFG_IDX_W-1:0] idx,
		logic [fgbph_pkg::CODE_W-1:0] val);
		case (idx)
			fgbph_pkg::CFG_FULL_SCALE: full_scale = val;
			fgbph_pkg::CFG_TOLERANCE:  tolerance = val;
			fgbph_pkg::CFG_MAX_FORCE:  force_span = val;
			default: ;
		endcase
	endfunction

	// truncating divide, saturated to the force range; zero divisor saturates by sign
	function longint ratio(longint num, longint den);
		longint q;
		if (den == 0)
			return (num >= 0) ? longint'(fgbph_pkg::FORCE_MAX) : longint'(fgbph_pkg::FORCE_MIN);
		q = num / den;
		if (q > longint'(fgbph_pkg::FORCE_MAX)) return longint'(fgbph_pkg::FORCE_MAX);
		if (q < longint'(fgbph_pkg::FORCE_MIN)) return longint'(fgbph_pkg::FORCE_MIN);
		return q;
	endfunction

	// two-branch map around the baseline
	function longint code_to_force(longint v);
		if (v > baseline - tolerance)
			return ratio(force_span * (v - baseline), full_scale - baseline);
		return ratio(force_span * (baseline - v), baseline);
	endfunction

	task flag(string what);
		mismatches++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	function void take_request(logic kind, logic [fgbph_pkg::CODE_W-1:0] code, logic last);
		longint        mean;
		force_report_t rep;
		if (kind == fgbph_pkg::KIND_EVENT) begin
			if (!calibrating)
				return;
			calibrating = 1'b0;
			block_acc   = 0;
			sample_n    = 0;
			baseline    = (block_total == 0) ? CODE_TOP : base_sum / block_total;
			if (baseline > CODE_TOP)
				baseline = CODE_TOP;
			rep.kind     = fgbph_pkg::REPORT_BASELINE;
			rep.mean     = '0;
			rep.peak     = peak_hold[fgbph_pkg::FORCE_W-1:0];
			rep.baseline = baseline[fgbph_pkg::CODE_W-1:0];
			reports_due.push_back(rep);
			return;
		end
		if (sample_n < COUNT_FULL) begin
			block_acc += calibrating ? longint'(code) : code_to_force(longint'(code));
			if (block_acc > longint'(fgbph_pkg::SUM_MAX)) block_acc = longint'(fgbph_pkg::SUM_MAX);
			if (block_acc < longint'(fgbph_pkg::SUM_MIN)) block_acc = longint'(fgbph_pkg::SUM_MIN);
			sample_n++;
		end
		if (!last)
			return;
		if (calibrating) begin
			if (block_total < CODE_TOP) begin
				mean = (sample_n != 0) ? block_acc / sample_n : CODE_TOP;
				if (mean > CODE_TOP)
					mean = CODE_TOP;
				base_sum += mean;
				if (base_sum > BASE_TOP)
					base_sum = BASE_TOP;
				block_total++;
			end
			block_acc = 0;
			sample_n  = 0;
			return;
		end
		mean      = ratio(block_acc, sample_n);
		block_acc = 0;
		sample_n  = 0;
		if (peak_hold < mean)
			peak_hold = mean;
		rep.kind     = fgbph_pkg::REPORT_FORCE;
		rep.mean     = mean[fgbph_pkg::FORCE_W-1:0];
		rep.peak     = peak_hold[fgbph_pkg::FORCE_W-1:0];
		rep.baseline = baseline[fgbph_pkg::CODE_W-1:0];
		reports_due.push_back(rep);
	endfunction

	task check_report(force_report_t got);
		force_report_t want;
		if (reports_due.size() == 0) begin
			flag($sformatf("unexpected report kind %0d mean %0d peak %0d baseline %0d",
				got.kind, got.mean, got.peak, got.baseline));
			return;
		end
		want = reports_due.pop_front();
		if (got.kind !== want.kind)
			flag($sformatf("report_kind got %0d, expected %0d", got.kind, want.kind));
		if (got.mean !== want.mean)
			flag($sformatf("mean_force got %0d, expected %0d", got.mean, want.mean));
		if (got.peak !== want.peak)
			flag($sformatf("peak_force got %0d, expected %0d", got.peak, want.peak));
		if (got.baseline !== want.baseline)
			flag($sformatf("baseline_code got %0d, expected %0d", got.baseline, want.baseline));
	endtask
endclass

module tb_force_gauge_baseline_peak_hold;
	localparam int CLK_PERIOD     = 12;
	localparam int RESET_CYCLES   = 6;
	localparam int IDLE_PCT       = 14;
	// longest run without any handshake that the watchdog allows
	localparam int WATCHDOG_LIMIT = 5000;
	// two serial divider passes plus margin
	localparam int SETTLE_CYCLES  = 120;
	localparam int HOLD_CYCLES    = 400;
	localparam int RANDOM_ITEMS   = 1500;
	localparam int PHASES         = 6;
	// a longer calibration block
	localparam int LONG_BLOCK     = 40;
	localparam int CW             = fgbph_pkg::CODE_W;
	localparam int FW             = fgbph_pkg::FORCE_W;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            cfg_we    = 1'b0;
	logic [fgbph_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [CW-1:0]                   cfg_data  = '0;
	logic                            s_tvalid  = 1'b0;
	logic                            s_tready;
	logic [fgbph_pkg::S_TDATA_W-1:0] s_tdata   = '0;
	logic                            s_tuser   = 1'b0;
	logic                            s_tlast   = 1'b0;
	logic                            m_tvalid;
	logic                            m_tready  = 1'b0;
	logic [fgbph_pkg::M_TDATA_W-1:0] m_tdata;
	logic                            m_tuser;

	force_gauge_tracker sb = new();

	// idle odds per side; zeroed for the stretch with no gaps
	int tx_idle_pct  = IDLE_PCT;
	int rx_idle_pct  = IDLE_PCT;
	int reports_seen = 0;
	int quiet_cycles = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	force_gauge_baseline_peak_hold #(
		.SAMPLE_COUNT_BITS(fgbph_pkg::SAMPLE_COUNT_BITS_DEF)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	// watchdog: ends the run when no handshake happens for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// report sink: checks each accepted report, stalls at random,
	// and after the 40th and the 400th report holds off long enough for the block to back up its input
	initial begin : report_sink
		int            hold_left;
		force_report_t got;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				got.kind     = m_tuser;
				got.mean     = m_tdata[FW-1:0];
				got.peak     = m_tdata[2*FW-1:FW];
				got.baseline = m_tdata[2*FW+CW-1:2*FW];
				sb.check_report(got);
				reports_seen++;
				if (reports_seen == 40 || reports_seen == 400)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// one request; valid stays high into the next request unless the sender idles
	task automatic send_request(logic kind, logic [CW-1:0] code, logic last);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= code;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.take_request(kind, code, last);
	endtask

	// mostly codes near a center, some across the whole range
	function automatic logic [CW-1:0] pick_code(int center, int spread, int wide_pct);
		int v;
		if ($urandom_range(99) < wide_pct)
			return CW'($urandom_range(65535));
		v = center + int'($urandom_range(2 * spread)) - spread;
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return v[CW-1:0];
	endfunction

	task automatic send_block(int len, int center, int spread, int wide_pct);
		for (int i = 0; i < len; i++)
			send_request(fgbph_pkg::KIND_SAMPLE, pick_code(center, spread, wide_pct),
				i == len - 1);
	endtask

	// sender pauses until every owed report is in, then lets a trailing
	// sample that owes nothing work through the divider
	task automatic wait_reports_done();
		s_tvalid <= 1'b0;
		while (sb.reports_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [fgbph_pkg::CFG_IDX_W-1:0] idx, logic [CW-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	// registers change only with the block idle
	task automatic new_setting(logic [CW-1:0] fs, logic [CW-1:0] tol, logic [CW-1:0] span);
		wait_reports_done();
		write_reg(fgbph_pkg::CFG_FULL_SCALE, fs);
		write_reg(fgbph_pkg::CFG_TOLERANCE, tol);
		write_reg(fgbph_pkg::CFG_MAX_FORCE, span);
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		int center;
		int base;
		int sent;
		int len;
		repeat (RESET_CYCLES)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		new_setting(fgbph_pkg::FULL_SCALE_RST, fgbph_pkg::TOLERANCE_RST,
			fgbph_pkg::MAX_FORCE_RST);

		// calibration: extreme codes in one block and as single-sample blocks
		center = $urandom_range(20000, 45000);
		send_request(fgbph_pkg::KIND_SAMPLE, 16'h0000, 1'b0);
		send_request(fgbph_pkg::KIND_SAMPLE, 16'hFFFF, 1'b1);
		send_request(fgbph_pkg::KIND_SAMPLE, 16'h0000, 1'b1);
		send_request(fgbph_pkg::KIND_SAMPLE, 16'hFFFF, 1'b1);
		// short blocks around the chosen resting level
		repeat (8)
			send_block($urandom_range(1, 12), center, 1500, 10);
		send_block(LONG_BLOCK, center, 4000, 10);
		// partial block gets dropped by the end of calibration
		send_request(fgbph_pkg::KIND_SAMPLE, CW'($urandom_range(65535)), 1'b0);
		send_request(fgbph_pkg::KIND_SAMPLE, CW'($urandom_range(65535)), 1'b0);
		send_request(fgbph_pkg::KIND_EVENT, CW'($urandom_range(65535)), 1'($urandom_range(1)));
		// a second end-of-calibration request is ignored
		send_request(fgbph_pkg::KIND_EVENT, CW'($urandom_range(65535)), 1'($urandom_range(1)));
		wait_reports_done();
		base = int'(sb.baseline);

		// reset setting: extreme codes, the tolerance edge, a mixed block
		send_request(fgbph_pkg::KIND_SAMPLE, 16'h0000, 1'b1);
		send_request(fgbph_pkg::KIND_SAMPLE, 16'hFFFF, 1'b1);
		send_request(fgbph_pkg::KIND_SAMPLE, CW'(base), 1'b1);
		send_request(fgbph_pkg::KIND_SAMPLE, CW'(base - 308), 1'b1);
		send_request(fgbph_pkg::KIND_SAMPLE, CW'(base - 307), 1'b1);
		send_request(fgbph_pkg::KIND_SAMPLE, 16'hFFFF, 1'b0);
		send_request(fgbph_pkg::KIND_SAMPLE, 16'h0000, 1'b0);
		send_request(fgbph_pkg::KIND_SAMPLE, CW'(base), 1'b1);

		// full scale at the baseline: upper branch divides by zero
		new_setting(CW'(base), 16'd10, fgbph_pkg::MAX_FORCE_RST);
		send_request(fgbph_pkg::KIND_SAMPLE, CW'(base + 5), 1'b1);
		send_request(fgbph_pkg::KIND_SAMPLE, CW'(base - 3), 1'b1);
		send_request(fgbph_pkg::KIND_SAMPLE, CW'(base - 11), 1'b1);

		// full scale below the baseline: negative divisor, widest force span
		new_setting(16'd1, 16'd0, 16'hFFFF);
		send_request(fgbph_pkg::KIND_SAMPLE, 16'hFFFF, 1'b1);
		send_request(fgbph_pkg::KIND_SAMPLE, CW'(base + 1), 1'b1);

		// random blocks under several settings, extremes toward the end since the
		// peak holds once it saturates
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					new_setting(fgbph_pkg::FULL_SCALE_RST, fgbph_pkg::TOLERANCE_RST,
						fgbph_pkg::MAX_FORCE_RST);
				end
				1: begin
					new_setting(CW'($urandom_range(1, 65535)), CW'($urandom_range(2000)),
						CW'($urandom_range(65535)));
				end
				2: begin
					new_setting(CW'($urandom_range(base, 65535)), CW'($urandom_range(400)),
						CW'($urandom_range(8000)));
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
				3: begin
					new_setting(CW'(base), CW'($urandom_range(400)), CW'($urandom_range(65535)));
				end
				4: begin
					new_setting(CW'($urandom_range(1, base)), 16'd0, 16'd0);
				end
				default: begin
					new_setting(16'hFFFF, 16'hFFFF, 16'hFFFF);
				end
			endcase
			sent = 0;
			while (sent < RANDOM_ITEMS / PHASES) begin
				// stray end-of-calibration requests, ignored from here on
				if ($urandom_range(99) < 3)
					send_request(fgbph_pkg::KIND_EVENT, CW'($urandom_range(65535)),
						1'($urandom_range(1)));
				len = ($urandom_range(19) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
				send_block(len, base, 400, 50);
				sent += len;
			end
			tx_idle_pct = IDLE_PCT;
			rx_idle_pct = IDLE_PCT;
		end

		wait_reports_done();
		if (sb.mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule

FILE: files.f
+incdir+hdl
hdl/fgbph_pkg.sv
hdl/fgbph_div.sv
hdl/force_gauge_baseline_peak_hold.sv
hdl/fgbph_checker.sv
sim/tb_force_gauge_baseline_peak_hold.sv
